@@ rtl/sufb_pkg.sv @@
package sufb_pkg;

   // Transaction opcodes on the request channel.
   localparam logic [2:0] OP_HOST_BYTE  = 3'd0;
   localparam logic [2:0] OP_LOCAL_READ = 3'd1;
   localparam logic [2:0] OP_LOCAL_WR   = 3'd2;
   localparam logic [2:0] OP_TX_DONE    = 3'd3;
   localparam logic [2:0] OP_FLUSH_ALL  = 3'd4;
   localparam logic [2:0] OP_FLUSH_RX   = 3'd5;
   localparam logic [2:0] OP_LINE_STATE = 3'd6;

   // Result kinds on the response channel.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_PACKET = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_DRAIN_ISSUE,
      ST_DRAIN
   } sufb_state_type;

   // Status reported with every result of one transaction.
   typedef struct packed {
      logic       accepted;
      logic       was_empty;
      logic       rearm_rx;
      logic       dtr;
      logic       rts;
      logic [7:0] rx_count;
      logic       tx_full;
   } sufb_status_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [7:0]      byte_out;
      logic            packet_end;
      sufb_status_type status;
   } sufb_result_type;

endpackage

@@ rtl/sufb_req_if.sv @@
interface sufb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] data;
   logic       last;
   logic [9:0] packet_len;

   modport source (output valid, output opcode, output data, output last,
                   output packet_len, input ready);
   modport sink (input valid, input opcode, input data, input last,
                 input packet_len, output ready);
endinterface

@@ rtl/sufb_rsp_if.sv @@
interface sufb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_out;
   logic       packet_end;
   logic       accepted;
   logic       was_empty;
   logic       rearm_rx;
   logic       dtr;
   logic       rts;
   logic [7:0] rx_count;
   logic       tx_full;

   modport source (output valid, output kind, output byte_out, output packet_end,
                   output accepted, output was_empty, output rearm_rx, output dtr,
                   output rts, output rx_count, output tx_full, input ready);
   modport sink (input valid, input kind, input byte_out, input packet_end,
                 input accepted, input was_empty, input rearm_rx, input dtr,
                 input rts, input rx_count, input tx_full, output ready);
endinterface

@@ rtl/sufb_ram.sv @@
module sufb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/serial_usb_fifo_bridge_unit.sv @@
// Byte bridge between a USB bulk endpoint and a local byte interface.
// Every request transaction (host byte, local read, local write, tx done, flush all,
// flush rx, line state, or a no-operation code) produces one or more response
// transactions. All responses of one request carry the same status fields, taken
// after the request has been applied; packet_end marks the final response.
// Host bytes go into the receive ring and local writes into the transmit ring, each
// held in a single-port-per-side synchronous RAM with a registered read port.
// Timing: a request is taken only when the control sequencer is idle and the output
// register is free. Ring writes that start no drain, flushes and line-state updates
// answer in the cycle after acceptance, so they sustain one transaction per cycle
// while the receiver does not stall. A local read that finds data waits in ST_RD_WAIT
// for the receive RAM read. A kick that sends n packet bytes (n at most MAX_PACKET-1)
// is accepted, issues the first transmit RAM read in ST_DRAIN_ISSUE, then sends one
// byte per cycle unless the receiver stalls; the transmit RAM read port sets that rate.
// Reset clears all ring pointers, the NAK and busy flags and the line state and
// loads the NAK threshold with 128; RAM contents are not cleared.
// When the receiver stalls, the pending response is held in the output register and
// no new request is taken, and a packet drain pauses with its next byte held.
module serial_usb_fifo_bridge_unit #(
   parameter int RX_DEPTH   = 256,
   parameter int TX_DEPTH   = 256,
   parameter int MAX_PACKET = 64
) (
   input logic        clock,
   input logic        reset,
   sufb_req_if.sink   req_chan,
   sufb_rsp_if.source rsp_chan,
   input logic        csr_wr_en,
   input logic [7:0]  csr_wr_data
);

   import sufb_pkg::*;

   localparam int RW = $clog2(RX_DEPTH);
   localparam int TW = $clog2(TX_DEPTH);
   localparam int CW = $clog2(MAX_PACKET);

   // Sequencer and ring state.
   sufb_state_type  state_ff, state_in;
   logic [RW-1:0]   rx_wp_ff, rx_wp_in;
   logic [RW-1:0]   rx_rp_ff, rx_rp_in;
   logic [TW-1:0]   tx_wp_ff, tx_wp_in;
   logic [TW-1:0]   tx_rp_ff, tx_rp_in;
   logic            nak_ff, nak_in;
   logic            busy_ff, busy_in;
   logic [1:0]      line_ff, line_in;
   logic [7:0]      thr_ff;
   logic [TW-1:0]   drain_addr_ff, drain_addr_in;
   logic [CW-1:0]   drain_left_ff, drain_left_in;
   sufb_status_type stat_ff, stat_in;
   logic            out_valid_ff, out_valid_in;
   sufb_result_type out_ff, out_in;

   // Handshake.
   logic req_fire;
   logic out_free;

   // Per-request decode.
   logic            step_rd;
   logic            step_drain;
   logic [CW-1:0]   step_count;
   logic [RW-1:0]   rx_next;
   logic [TW-1:0]   tx_next;
   logic [RW-1:0]   rx_used;
   logic [RW:0]     room_sum;
   logic            rx_room;
   logic [TW-1:0]   tx_used;
   logic            kick_req;
   logic            resume_chk;

   // RAM ports.
   logic            rx_wr_en, rx_rd_en;
   logic            tx_wr_en, tx_rd_en;
   logic [TW-1:0]   tx_rd_addr;
   logic [7:0]      rx_rd_data, tx_rd_data;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   sufb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_next),
      .wr_data (req_chan.data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rp_in),
      .rd_data (rx_rd_data)
   );

   sufb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_next),
      .wr_data (req_chan.data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // Apply one request to the ring state. All values here are the state after the
   // request; they are committed only when the request transaction completes.
   always_comb begin
      rx_next    = rx_wp_ff + RW'(1);
      tx_next    = tx_wp_ff + TW'(1);
      rx_wp_in   = rx_wp_ff;
      rx_rp_in   = rx_rp_ff;
      tx_wp_in   = tx_wp_ff;
      tx_rp_in   = tx_rp_ff;
      nak_in     = nak_ff;
      busy_in    = busy_ff;
      line_in    = line_ff;
      stat_in    = '0;
      step_rd    = 1'b0;
      kick_req   = 1'b0;
      resume_chk = 1'b0;
      rx_wr_en   = 1'b0;
      tx_wr_en   = 1'b0;

      case (req_chan.opcode)
         OP_HOST_BYTE: begin
            // Bytes of oversized packets are dropped; a full ring also drops.
            if (req_chan.packet_len <= 10'(MAX_PACKET) && rx_next != rx_rp_ff) begin
               rx_wp_in         = rx_next;
               rx_wr_en         = req_fire;
               stat_in.accepted = 1'b1;
            end
         end
         OP_LOCAL_READ: begin
            if (rx_wp_ff == rx_rp_ff) begin
               stat_in.was_empty = 1'b1;
            end else begin
               rx_rp_in = rx_rp_ff + RW'(1);
               step_rd  = 1'b1;
            end
            resume_chk = 1'b1;
         end
         OP_LOCAL_WR: begin
            if (tx_next != tx_rp_ff) begin
               tx_wp_in         = tx_next;
               tx_wr_en         = req_fire;
               stat_in.accepted = 1'b1;
            end
            // The end of a write run kicks the ring only if its final byte was stored.
            kick_req = req_chan.last && stat_in.accepted;
         end
         OP_TX_DONE: begin
            busy_in  = 1'b0;
            kick_req = 1'b1;
         end
         OP_FLUSH_ALL: begin
            rx_wp_in   = '0;
            rx_rp_in   = '0;
            tx_wp_in   = '0;
            tx_rp_in   = '0;
            resume_chk = 1'b1;
         end
         OP_FLUSH_RX: begin
            rx_wp_in   = '0;
            rx_rp_in   = '0;
            resume_chk = 1'b1;
         end
         OP_LINE_STATE: begin
            line_in = req_chan.data[1:0];
         end
         default: begin
         end
      endcase

      // Free space test: used + threshold < RX_DEPTH.
      rx_used  = rx_wp_in - rx_rp_in;
      room_sum = {1'b0, rx_used} + (RW + 1)'(thr_ff);
      rx_room  = !room_sum[RW];

      if (req_chan.opcode == OP_HOST_BYTE && req_chan.last) begin
         // The flow decision is made at every packet end, even for dropped packets.
         if (rx_room) begin
            stat_in.rearm_rx = 1'b1;
         end else begin
            nak_in = 1'b1;
         end
      end
      if (resume_chk && nak_ff && rx_room) begin
         nak_in           = 1'b0;
         stat_in.rearm_rx = 1'b1;
      end

      // A kick sends up to MAX_PACKET-1 bytes unless a packet is still in flight.
      tx_used    = tx_wp_in - tx_rp_in;
      step_count = (tx_used > TW'(MAX_PACKET - 1)) ? CW'(MAX_PACKET - 1) : tx_used[CW-1:0];
      step_drain = kick_req && !busy_in && (step_count != '0);
      if (step_drain) begin
         busy_in  = 1'b1;
         tx_rp_in = tx_rp_ff + TW'(step_count);
      end

      stat_in.dtr      = line_in[0];
      stat_in.rts      = line_in[1];
      stat_in.rx_count = (rx_used > RW'(255)) ? 8'hFF : rx_used[7:0];
      stat_in.tx_full  = (tx_wp_in + TW'(1)) == tx_rp_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && step_rd) begin
               state_in = ST_RD_WAIT;
            end else if (req_fire && step_drain) begin
               state_in = ST_DRAIN_ISSUE;
            end
         end
         ST_RD_WAIT: begin
            state_in = ST_IDLE;
         end
         ST_DRAIN_ISSUE: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (out_free && drain_left_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: RAM reads, drain bookkeeping and the output register.
   always_comb begin
      rx_rd_en      = 1'b0;
      tx_rd_en      = 1'b0;
      tx_rd_addr    = drain_addr_ff;
      drain_addr_in = drain_addr_ff;
      drain_left_in = drain_left_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rx_rd_en = step_rd;
               // The first transmit read is issued from ST_DRAIN_ISSUE so that it never meets the
               // write of the same entry made by this transaction.
               drain_addr_in = tx_rp_ff + TW'(1);
               drain_left_in = step_count;
               if (!step_rd && !step_drain) begin
                  out_valid_in       = 1'b1;
                  out_in.kind        = (req_chan.opcode == OP_LOCAL_READ) ? KIND_READ
                                                                          : KIND_STATUS;
                  out_in.byte_out    = '0;
                  out_in.packet_end  = 1'b1;
                  out_in.status      = stat_in;
               end
            end
         end
         ST_RD_WAIT: begin
            out_valid_in      = 1'b1;
            out_in.kind       = KIND_READ;
            out_in.byte_out   = rx_rd_data;
            out_in.packet_end = 1'b1;
            out_in.status     = stat_ff;
         end
         ST_DRAIN_ISSUE: begin
            tx_rd_en      = 1'b1;
            drain_addr_in = drain_addr_ff + TW'(1);
         end
         ST_DRAIN: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_in.kind       = KIND_PACKET;
               out_in.byte_out   = tx_rd_data;
               out_in.packet_end = (drain_left_ff == CW'(1));
               out_in.status     = stat_ff;
               drain_left_in     = drain_left_ff - CW'(1);
               if (drain_left_ff != CW'(1)) begin
                  tx_rd_en      = 1'b1;
                  drain_addr_in = drain_addr_ff + TW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rx_wp_ff     <= '0;
         rx_rp_ff     <= '0;
         tx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         nak_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         line_ff      <= '0;
         thr_ff       <= 8'd128;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (req_fire) begin
            rx_wp_ff <= rx_wp_in;
            rx_rp_ff <= rx_rp_in;
            tx_wp_ff <= tx_wp_in;
            tx_rp_ff <= tx_rp_in;
            nak_ff   <= nak_in;
            busy_ff  <= busy_in;
            line_ff  <= line_in;
         end
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      out_ff        <= out_in;
      drain_addr_ff <= drain_addr_in;
      drain_left_ff <= drain_left_in;
      if (req_fire) begin
         stat_ff <= stat_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_ff.kind;
   assign rsp_chan.byte_out   = out_ff.byte_out;
   assign rsp_chan.packet_end = out_ff.packet_end;
   assign rsp_chan.accepted   = out_ff.status.accepted;
   assign rsp_chan.was_empty  = out_ff.status.was_empty;
   assign rsp_chan.rearm_rx   = out_ff.status.rearm_rx;
   assign rsp_chan.dtr        = out_ff.status.dtr;
   assign rsp_chan.rts        = out_ff.status.rts;
   assign rsp_chan.rx_count   = out_ff.status.rx_count;
   assign rsp_chan.tx_full    = out_ff.status.tx_full;

   // The receive RAM read wait state is always followed by the read response in the next cycle.
   a_read_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_WAIT |=> out_valid_ff)
      else $error("local read response missing");

   // A packet drain only runs with bytes left and with the endpoint marked busy.
   a_drain_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> drain_left_ff != '0 && busy_ff)
      else $error("packet drain without bytes or busy flag");

   // The last packet byte returns the sequencer to idle.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && out_free && drain_left_ff == CW'(1) |=>
         state_ff == ST_IDLE && out_valid_ff && out_ff.packet_end)
      else $error("packet drain did not end cleanly");

endmodule
